// ===== rtl/core/ffra_pkg.sv =====
package ffra_pkg;

   localparam int LEN_W = 17;
   localparam int OFF_W = 16;

   localparam logic [LEN_W-1:0] POOL_MIN = 17'd2;
   localparam logic [LEN_W-1:0] POOL_MAX = 17'd65536;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] ST_FREE_FAIL  = 2'd2;

   typedef enum logic [1:0] {
      MODE_SEARCH,
      MODE_INSERT,
      MODE_SHIFT,
      MODE_DONE
   } mode_type;

   typedef struct packed {
      logic             active;
      logic             cmd;
      mode_type         mode;
      logic             full;
      logic [OFF_W-1:0] req_size;
      logic [OFF_W-1:0] addr;
      logic [LEN_W-1:0] pos;
      logic [LEN_W-1:0] carry_len;
      logic             carry_busy;
      logic [LEN_W-1:0] sum;
      logic [1:0]       status;
      logic [OFF_W-1:0] offset;
      logic             inc;
      logic             dec;
   } wave_type;

endpackage

// ===== rtl/core/ffra_cell.sv =====
module ffra_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [ffra_pkg::LEN_W-1:0]    load_len,
   input  logic                          load_busy,
   input  ffra_pkg::wave_type            wave_i,
   input  logic [ffra_pkg::LEN_W-1:0]    next_len,
   input  logic                          next_busy,
   output logic [ffra_pkg::LEN_W-1:0]    len_o,
   output logic                          busy_o,
   output ffra_pkg::wave_type            wave_o
);

   logic [ffra_pkg::LEN_W-1:0] len_ff, len_in;
   logic                       busy_ff, busy_in;
   ffra_pkg::wave_type         wave_ff, wave_in;

   always_comb begin
      wave_in = wave_i;
      len_in  = len_ff;
      busy_in = busy_ff;
      if (wave_i.active) begin
         unique case (wave_i.mode)
            ffra_pkg::MODE_SEARCH: begin
               if (wave_i.cmd == ffra_pkg::CMD_ALLOC) begin
                  if (!busy_ff && len_ff != '0 &&
                      len_ff >= {1'b0, wave_i.req_size}) begin
                     if (len_ff == {1'b0, wave_i.req_size}) begin
                        busy_in        = 1'b1;
                        wave_in.status = ffra_pkg::ST_OK;
                        wave_in.offset = wave_i.pos[ffra_pkg::OFF_W-1:0];
                        wave_in.mode   = ffra_pkg::MODE_DONE;
                     end else if (!wave_i.full) begin
                        len_in             = {1'b0, wave_i.req_size};
                        busy_in            = 1'b1;
                        wave_in.carry_len  = len_ff - {1'b0, wave_i.req_size};
                        wave_in.carry_busy = 1'b0;
                        wave_in.status     = ffra_pkg::ST_OK;
                        wave_in.offset     = wave_i.pos[ffra_pkg::OFF_W-1:0];
                        wave_in.inc        = 1'b1;
                        wave_in.mode       = ffra_pkg::MODE_INSERT;
                     end else begin
                        wave_in.mode = ffra_pkg::MODE_DONE;
                     end
                  end else begin
                     wave_in.pos = wave_i.pos + len_ff;
                  end
               end else begin
                  if (len_ff != '0 && wave_i.pos == {1'b0, wave_i.addr}) begin
                     busy_in        = 1'b0;
                     wave_in.status = ffra_pkg::ST_OK;
                     if (next_len != '0 && !next_busy) begin
                        len_in       = len_ff + next_len;
                        wave_in.dec  = 1'b1;
                        wave_in.mode = ffra_pkg::MODE_SHIFT;
                     end else begin
                        wave_in.mode = ffra_pkg::MODE_DONE;
                     end
                  end else begin
                     wave_in.pos = wave_i.pos + len_ff;
                  end
               end
            end
            ffra_pkg::MODE_INSERT: begin
               len_in             = wave_i.carry_len;
               busy_in            = wave_i.carry_busy;
               wave_in.carry_len  = len_ff;
               wave_in.carry_busy = busy_ff;
            end
            ffra_pkg::MODE_SHIFT: begin
               len_in  = next_len;
               busy_in = next_busy;
            end
            ffra_pkg::MODE_DONE: begin
            end
            default: begin
            end
         endcase
         if (!busy_in) begin
            wave_in.sum = wave_i.sum + len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || load) begin
         len_ff  <= load_len;
         busy_ff <= load_busy;
      end else if (wave_i.active) begin
         len_ff  <= len_in;
         busy_ff <= busy_in;
      end
      if (reset) begin
         wave_ff <= '0;
      end else begin
         wave_ff <= wave_in;
      end
   end

   assign len_o  = len_ff;
   assign busy_o = busy_ff;
   assign wave_o = wave_ff;

endmodule

// ===== rtl/core/first_fit_region_allocator.sv =====
// First-fit region allocator.
// Input: a transaction is taken at a clock edge with start high and busy low.
//   req_cmd 0 allocates req_size bytes, 1 frees the region at req_free_offset.
// Result: rsp_valid is high for one cycle with rsp_alloc_offset, rsp_status
//   (0 ok, 1 allocate failed, 2 free refused) and rsp_free_bytes. The
//   receiver cannot stall; every result must be taken in its cycle.
// Config: csr_wr_en with csr_wr_data sets the pool size (clamped to 2..65536)
//   and reinitializes the region table at that clock edge.
// Structure: one cell per region table entry; each transaction travels down
//   the row one cell per cycle, searching, splitting (shift right) or merging
//   (shift left) as it passes and summing the free bytes.
// Flow: the transaction passes the launch register and then every cell of the
//   row before rsp_valid rises, and the result is taken at the edge closing
//   that cycle. busy stays high through the result cycle and drops at its
//   closing edge, so no new transaction is taken until the previous result
//   has been given.
// Reset: synchronous; pool size 65536, table holds the null region and one
//   free region of 65535 bytes, no transaction in flight.
module first_fit_region_allocator #(
   parameter int MAX_REGIONS = 16,
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_size,
   input  logic [15:0] req_free_offset,
   output logic        rsp_valid,
   output logic [15:0] rsp_alloc_offset,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_free_bytes,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam logic [15:0] OFF_MASK = (OFFSET_BITS >= 16) ? 16'hFFFF :
                                      16'((32'd1 << OFFSET_BITS) - 32'd1);

   logic [ffra_pkg::LEN_W-1:0] cell_len  [MAX_REGIONS+1];
   logic                       cell_busy [MAX_REGIONS+1];
   ffra_pkg::wave_type         wave      [MAX_REGIONS+1];
   ffra_pkg::wave_type         launch_ff, launch_in;

   logic                       busy_ff, busy_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       load;
   logic [ffra_pkg::LEN_W-1:0] pool_load;
   logic                       accept;
   ffra_pkg::wave_type         done_wave;

   assign load      = reset || csr_wr_en;
   assign accept    = start && !busy_ff;
   assign done_wave = wave[MAX_REGIONS];

   always_comb begin
      if (reset) begin
         pool_load = ffra_pkg::POOL_MAX;
      end else if (csr_wr_data < ffra_pkg::POOL_MIN) begin
         pool_load = ffra_pkg::POOL_MIN;
      end else if (csr_wr_data > ffra_pkg::POOL_MAX) begin
         pool_load = ffra_pkg::POOL_MAX;
      end else begin
         pool_load = csr_wr_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (done_wave.active) begin
         if (done_wave.inc) begin
            count_in = count_ff + CNT_W'(1);
         end else if (done_wave.dec) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      if (load) begin
         count_in = CNT_W'(2);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (done_wave.active) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_comb begin
      launch_in          = '0;
      launch_in.active   = accept;
      launch_in.cmd      = req_cmd;
      launch_in.req_size = req_size;
      launch_in.addr     = req_free_offset;
      launch_in.full     = (count_in == CNT_W'(MAX_REGIONS));
      launch_in.status   = (req_cmd == ffra_pkg::CMD_FREE) ? ffra_pkg::ST_FREE_FAIL
                                                           : ffra_pkg::ST_ALLOC_FAIL;
      if ((req_cmd == ffra_pkg::CMD_ALLOC && req_size == '0) ||
          (req_cmd == ffra_pkg::CMD_FREE && req_free_offset == '0)) begin
         launch_in.mode = ffra_pkg::MODE_DONE;
      end else begin
         launch_in.mode = ffra_pkg::MODE_SEARCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         count_ff  <= CNT_W'(2);
         launch_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         count_ff  <= count_in;
         launch_ff <= launch_in;
      end
   end

   assign wave[0]                = launch_ff;
   assign cell_len[MAX_REGIONS]  = '0;
   assign cell_busy[MAX_REGIONS] = 1'b0;

   for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
      logic [ffra_pkg::LEN_W-1:0] init_len;
      assign init_len = (k == 0) ? ffra_pkg::LEN_W'(1) :
                        (k == 1) ? pool_load - ffra_pkg::LEN_W'(1) : '0;
      ffra_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (load),
         .load_len  (init_len),
         .load_busy (k == 0),
         .wave_i    (wave[k]),
         .next_len  (cell_len[k+1]),
         .next_busy (cell_busy[k+1]),
         .len_o     (cell_len[k]),
         .busy_o    (cell_busy[k]),
         .wave_o    (wave[k+1])
      );
   end

   assign busy             = busy_ff;
   assign rsp_valid        = done_wave.active;
   assign rsp_alloc_offset = done_wave.offset & OFF_MASK;
   assign rsp_status       = done_wave.status;
   assign rsp_free_bytes   = done_wave.sum[15:0];

endmodule

// ===== rtl/core/ffra_checker.sv =====
module ffra_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [15:0] rsp_alloc_offset,
   input logic [1:0]  rsp_status
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ffra_pkg::ST_OK ||
                    rsp_status == ffra_pkg::ST_ALLOC_FAIL ||
                    rsp_status == ffra_pkg::ST_FREE_FAIL)
      else $error("undefined status code");

   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ffra_pkg::ST_OK |-> rsp_alloc_offset == 16'd0)
      else $error("nonzero offset on failed transaction");

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_alloc_offset (rsp_alloc_offset),
   .rsp_status       (rsp_status)
);

// ===== tb/first_fit_region_allocator_checker.sv =====
`timescale 1ns / 1ps

module first_fit_region_allocator_checker #(
   parameter int MAX_REGIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_size,
   input  logic [15:0] req_free_offset,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_alloc_offset,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_free_bytes,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   output int          fail_count,
   output int          pending,
   output int          ok_allocs,
   output int          ok_frees,
   output int          refused
);

   typedef struct packed {
      logic [15:0] offset;
      logic [1:0]  status;
      logic [15:0] free_bytes;
   } outcome_type;

   logic [ffra_pkg::LEN_W-1:0] seg_len [MAX_REGIONS];
   logic                       seg_used[MAX_REGIONS];
   int                         seg_count;
   outcome_type                outcome_q[$];

   function automatic void init_table(logic [ffra_pkg::LEN_W-1:0] psize);
      for (int k = 0; k < MAX_REGIONS; k++) begin
         seg_len[k] = '0;
         seg_used[k] = 1'b0;
      end
      seg_len[0] = ffra_pkg::LEN_W'(1);
      seg_used[0] = 1'b1;
      seg_len[1] = psize - ffra_pkg::LEN_W'(1);
      seg_count = 2;
   endfunction

   function automatic outcome_type apply_op(logic cmd, logic [15:0] sz, logic [15:0] addr);
      outcome_type o;
      int i;
      logic [ffra_pkg::LEN_W-1:0] pos;
      logic [ffra_pkg::LEN_W-1:0] total;
      o = '0;
      pos = '0;
      if (cmd == ffra_pkg::CMD_ALLOC) begin
         o.status = ffra_pkg::ST_ALLOC_FAIL;
         if (sz != 0) begin
            for (i = 0; i < seg_count; i++) begin
               if (!seg_used[i] && seg_len[i] >= sz) break;
               pos += seg_len[i];
            end
            if (i < seg_count) begin
               if (seg_len[i] == sz) begin
                  seg_used[i] = 1'b1;
                  o.status = ffra_pkg::ST_OK;
                  o.offset = pos[15:0];
               end else if (seg_count < MAX_REGIONS) begin
                  for (int j = seg_count; j > i + 1; j--) begin
                     seg_len[j] = seg_len[j-1];
                     seg_used[j] = seg_used[j-1];
                  end
                  seg_len[i+1] = seg_len[i] - sz;
                  seg_used[i+1] = 1'b0;
                  seg_len[i] = sz;
                  seg_used[i] = 1'b1;
                  seg_count++;
                  o.status = ffra_pkg::ST_OK;
                  o.offset = pos[15:0];
               end
            end
         end
      end else begin
         o.status = ffra_pkg::ST_FREE_FAIL;
         if (addr != 0) begin
            for (i = 0; i < seg_count; i++) begin
               if (pos == addr) break;
               pos += seg_len[i];
            end
            if (i < seg_count && pos == addr) begin
               seg_used[i] = 1'b0;
               if (i + 1 < seg_count && !seg_used[i+1]) begin
                  seg_len[i] += seg_len[i+1];
                  for (int j = i + 1; j + 1 < seg_count; j++) begin
                     seg_len[j] = seg_len[j+1];
                     seg_used[j] = seg_used[j+1];
                  end
                  seg_len[seg_count-1] = '0;
                  seg_used[seg_count-1] = 1'b0;
                  seg_count--;
               end
               o.status = ffra_pkg::ST_OK;
            end
         end
      end
      total = '0;
      for (int k = 0; k < seg_count; k++)
         if (!seg_used[k]) total += seg_len[k];
      o.free_bytes = total[15:0];
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type e;
      logic [ffra_pkg::LEN_W-1:0] ps;
      if (reset) begin
         init_table(ffra_pkg::POOL_MAX);
         outcome_q.delete();
         fail_count <= 0;
         ok_allocs <= 0;
         ok_frees <= 0;
         refused <= 0;
      end else begin
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: off=%0d st=%0d free=%0d",
                           rsp_alloc_offset, rsp_status, rsp_free_bytes);
               fail_count <= fail_count + 1;
            end else begin
               e = outcome_q.pop_front();
               if (e.offset !== rsp_alloc_offset || e.status !== rsp_status ||
                   e.free_bytes !== rsp_free_bytes) begin
                  if (fail_count < 10)
                     $display({"mismatch: exp off=%0d st=%0d free=%0d,",
                               " got off=%0d st=%0d free=%0d"},
                              e.offset, e.status, e.free_bytes,
                              rsp_alloc_offset, rsp_status, rsp_free_bytes);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_wr_en) begin
            ps = csr_wr_data;
            if (ps < ffra_pkg::POOL_MIN) ps = ffra_pkg::POOL_MIN;
            if (ps > ffra_pkg::POOL_MAX) ps = ffra_pkg::POOL_MAX;
            init_table(ps);
         end
         if (start && !busy) begin
            e = apply_op(req_cmd, req_size, req_free_offset);
            outcome_q.push_back(e);
            if (e.status == ffra_pkg::ST_FREE_FAIL || e.status == ffra_pkg::ST_ALLOC_FAIL)
               refused <= refused + 1;
            else if (req_cmd == ffra_pkg::CMD_ALLOC) ok_allocs <= ok_allocs + 1;
            else ok_frees <= ok_frees + 1;
         end
      end
      pending = outcome_q.size();
   end

endmodule

// ===== tb/first_fit_region_allocator_test.sv =====
`timescale 1ns / 1ps

module first_fit_region_allocator_test;

   localparam int MAX_REGIONS = 16;
   localparam int WATCHDOG = 5000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_cmd;
   logic [15:0] req_size;
   logic [15:0] req_free_offset;
   logic        rsp_valid;
   logic [15:0] rsp_alloc_offset;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_free_bytes;
   logic        csr_wr_en;
   logic [16:0] csr_wr_data;
   int          fail_count;
   int          pending;
   int          ok_allocs;
   int          ok_frees;
   int          refused;
   int          quiet_cycles;
   bit          steady;
   logic [15:0] live_q[$];
   logic [16:0] cur_pool;

   first_fit_region_allocator #(.MAX_REGIONS(MAX_REGIONS), .OFFSET_BITS(16)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_size(req_size), .req_free_offset(req_free_offset),
      .rsp_valid(rsp_valid), .rsp_alloc_offset(rsp_alloc_offset),
      .rsp_status(rsp_status), .rsp_free_bytes(rsp_free_bytes),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   first_fit_region_allocator_checker #(.MAX_REGIONS(MAX_REGIONS)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_size(req_size), .req_free_offset(req_free_offset),
      .rsp_valid(rsp_valid), .rsp_alloc_offset(rsp_alloc_offset),
      .rsp_status(rsp_status), .rsp_free_bytes(rsp_free_bytes),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending), .ok_allocs(ok_allocs),
      .ok_frees(ok_frees), .refused(refused)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("watchdog expired");
         $display("first_fit_region_allocator_test failed");
         $finish;
      end
   end

   // track offsets handed out so frees mostly hit live regions
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_status == ffra_pkg::ST_OK && rsp_alloc_offset != 0)
         live_q.push_back(rsp_alloc_offset);

   task automatic send(logic cmd, logic [15:0] sz, logic [15:0] addr);
      @(negedge clock);
      if (!steady) begin
         while ($urandom_range(99) < 20) @(negedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_size <= sz;
      req_free_offset <= addr;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start <= 1'b0;
      req_cmd <= 1'($urandom_range(1));
      req_size <= 16'($urandom);
      req_free_offset <= 16'($urandom);
   endtask

   task automatic set_pool(logic [16:0] v);
      while (pending != 0) @(negedge clock);
      repeat (MAX_REGIONS + 4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_wr_data <= 17'($urandom);
      cur_pool = (v < 2) ? 17'd2 : (v > 65536) ? 17'd65536 : v;
      live_q.delete();
   endtask

   task automatic random_ops(int n);
      int pick;
      logic [15:0] sz;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            if ($urandom_range(9) == 0) sz = 16'($urandom);
            else sz = 16'($urandom_range(1, (cur_pool > 16) ? cur_pool / 6 : 2));
            send(ffra_pkg::CMD_ALLOC, sz, 16'($urandom));
         end else if (pick < 85 && live_q.size() > 0) begin
            int idx;
            idx = $urandom_range(live_q.size() - 1);
            send(ffra_pkg::CMD_FREE, 16'($urandom), live_q[idx]);
            live_q.delete(idx);
         end else begin
            send(ffra_pkg::CMD_FREE, 16'($urandom),
                 16'((pick < 92) ? $urandom_range(1) : $urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_cmd = ffra_pkg::CMD_ALLOC;
      req_size = '0;
      req_free_offset = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      steady = 1'b0;
      cur_pool = 17'd65536;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send(ffra_pkg::CMD_ALLOC, 16'd0, 16'hFFFF);
      send(ffra_pkg::CMD_ALLOC, 16'hFFFF, 16'h0);
      send(ffra_pkg::CMD_FREE, 16'h0, 16'hFFFF);
      send(ffra_pkg::CMD_FREE, 16'hFFFF, 16'd1);
      send(ffra_pkg::CMD_FREE, 16'h0, 16'd0);
      send(ffra_pkg::CMD_FREE, 16'h0, 16'd7);
      set_pool(17'd100);
      send(ffra_pkg::CMD_ALLOC, 16'd10, 16'd0);
      send(ffra_pkg::CMD_ALLOC, 16'd20, 16'd0);
      send(ffra_pkg::CMD_ALLOC, 16'd200, 16'd0);
      send(ffra_pkg::CMD_FREE, 16'd0, 16'd11);
      send(ffra_pkg::CMD_FREE, 16'd0, 16'd11);
      send(ffra_pkg::CMD_FREE, 16'd0, 16'd1);
      send(ffra_pkg::CMD_ALLOC, 16'd69, 16'd0);
      send(ffra_pkg::CMD_FREE, 16'd0, 16'd31);
      for (int k = 0; k < 15; k++) send(ffra_pkg::CMD_ALLOC, 16'd1, 16'd0);
      set_pool(17'd0);
      send(ffra_pkg::CMD_ALLOC, 16'd1, 16'd0);
      send(ffra_pkg::CMD_ALLOC, 16'd1, 16'd0);
      send(ffra_pkg::CMD_FREE, 16'd0, 16'd1);
      set_pool(17'h1FFFF);

      // random
      random_ops(100);
      steady = 1'b1;
      random_ops(60);
      steady = 1'b0;
      set_pool(17'd300);
      random_ops(80);
      set_pool(17'(17'd2 + $urandom_range(40)));
      random_ops(60);
      set_pool(17'd65536);
      random_ops(100);

      while (pending != 0) @(negedge clock);
      repeat (MAX_REGIONS + 4) @(negedge clock);
      $display("covered %0d good allocates, %0d good frees, %0d refusals",
               ok_allocs, ok_frees, refused);
      $display("pool sizes from 2 to 65536 with split, merge and full-table cases");
      if (fail_count == 0) $display("first_fit_region_allocator_test passed");
      else $display("first_fit_region_allocator_test failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ffra_pkg.sv
rtl/core/ffra_cell.sv
rtl/core/first_fit_region_allocator.sv
rtl/core/ffra_checker.sv
tb/first_fit_region_allocator_checker.sv
tb/first_fit_region_allocator_test.sv
